>>> hdl/ccp_pkg.sv
package ccp_pkg;

    localparam int COORD_BITS  = 16;
    localparam int CENTRE_BITS = 50;
    localparam int RADIUS_BITS = 51;

    // front arithmetic widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int D_W    = PROD_W + 2;
    localparam int BIG_W  = DIFF_W + SUM_W;
    localparam int XD_W   = COORD_BITS + D_W;
    localparam int NUM_W  = ((BIG_W > XD_W) ? BIG_W : XD_W) + 2;

    // divider and root widths
    localparam int QW        = CENTRE_BITS;
    localparam int DIV_CELLS = QW;
    localparam int CTR_W     = QW + 1;
    localparam int DX_W      = QW + 2;
    localparam int MAG_W     = QW + 1;
    localparam int HALF      = (MAG_W + 1) / 2;
    localparam int HH_W      = 2 * (MAG_W - HALF);
    localparam int HL_W      = MAG_W;
    localparam int LL_W      = 2 * HALF;
    localparam int RAD_W     = 2 * RADIUS_BITS;
    localparam int REM_W     = RADIUS_BITS + 3;
    localparam int ROOT_CELLS = RADIUS_BITS;

    // port packing
    localparam int IN_W      = 6 * COORD_BITS;
    localparam int IN_PAD_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = 2 * CENTRE_BITS + RADIUS_BITS;
    localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [QW-1:0]  acc;
    } div_lane_t;

    typedef struct packed {
        logic                         vld;
        logic                         deg;
        logic                         sgn_x;
        logic                         sgn_y;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic [D_W-1:0]               dmag;
        div_lane_t                    lane_x;
        div_lane_t                    lane_y;
    } div_word_t;

    typedef struct packed {
        logic                    vld;
        logic                    deg;
        logic signed [CTR_W-1:0] ox;
        logic signed [CTR_W-1:0] oy;
        logic [REM_W-1:0]        rem;
        logic [RADIUS_BITS-1:0]  root;
        logic [RAD_W-1:0]        rad;
    } root_word_t;

    // one restoring division step: shift in the next numerator bit
    function automatic div_lane_t div_step(input div_lane_t lane, input logic [D_W-1:0] dmag);
        logic [D_W:0] t;
        logic [D_W:0] diff;
        logic         ge;
        div_lane_t    res;
        t    = {lane.rem, lane.acc[QW-1]};
        diff = t - {1'b0, dmag};
        ge   = (t >= {1'b0, dmag});
        res.rem = ge ? diff[D_W-1:0] : t[D_W-1:0];
        res.acc = {lane.acc[QW-2:0], ge};
        return res;
    endfunction

endpackage

>>> hdl/circumcircle_from_three_points.sv
// Pipeline: 6 front stages, 50 divider cells, 6 squaring stages, 51 root cells and 1 output
// register; the first stage loads at the edge that accepts an input word.
// Throughput: one word per cycle while the skid entry is free; every divider and root cell works on a different word.
// A two-entry output stage holds results while the sink stalls; intake stops only when both
// entries are full.
// Reset (rst_n low, asynchronous) empties the pipeline and the output stage.
module circumcircle_from_three_points
    import ccp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [IN_PAD_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // centre_x, centre_y, circle_radius, zero fill
    output logic [OUT_PAD_W-1:0] m_tdata,
    // degenerate
    output logic                 m_tuser
);

    logic       en;
    logic       in_vld;
    div_word_t  div_chain  [DIV_CELLS+1];
    root_word_t root_chain [ROOT_CELLS+1];

    logic [OUT_W-1:0] res_next;
    logic             res_deg;
    logic             pop;
    logic             take;

    logic             out_vld_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_deg_reg;
    logic             skid_vld_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             skid_deg_reg;

    // the whole chain advances while the skid entry is free
    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign in_vld   = s_tvalid && en;

    ccp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (in_vld),
        .coords (s_tdata[IN_W-1:0]),
        .dout   (div_chain[0])
    );

    // restoring divider: one quotient bit per cell, x and y side by side
    for (genvar g = 0; g < DIV_CELLS; g++)
    begin : g_div
        ccp_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (div_chain[g]),
            .dout  (div_chain[g+1])
        );
    end

    ccp_square u_square (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (div_chain[DIV_CELLS]),
        .dout  (root_chain[0])
    );

    // digit-by-digit square root: one root bit per cell
    for (genvar g = 0; g < ROOT_CELLS; g++)
    begin : g_root
        ccp_root_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (root_chain[g]),
            .dout  (root_chain[g+1])
        );
    end

    // collinear points force every numeric field to zero
    always_comb
    begin
        res_deg = root_chain[ROOT_CELLS].deg;
        if (res_deg)
        begin
            res_next = '0;
        end
        else
        begin
            res_next = {root_chain[ROOT_CELLS].root,
                        root_chain[ROOT_CELLS].oy[CENTRE_BITS-1:0],
                        root_chain[ROOT_CELLS].ox[CENTRE_BITS-1:0]};
        end
    end

    assign pop  = en && root_chain[ROOT_CELLS].vld;
    assign take = out_vld_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            // drain the skid entry into the output register
            if (take)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (pop)
        begin
            if (out_vld_reg && !take)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
                out_deg_reg  <= skid_deg_reg;
            end
        end
        else if (pop)
        begin
            if (out_vld_reg && !take)
            begin
                skid_data_reg <= res_next;
                skid_deg_reg  <= res_deg;
            end
            else
            begin
                out_data_reg <= res_next;
                out_deg_reg  <= res_deg;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_PAD_W'(out_data_reg);
    assign m_tuser  = out_deg_reg;

endmodule

>>> hdl/ccp_front.sv
module ccp_front
    import ccp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [IN_W-1:0] coords,
    output div_word_t       dout
);

    logic signed [COORD_BITS-1:0] pt [6];

    logic                         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [COORD_BITS-1:0] x1_1_reg, y1_1_reg, x1_2_reg, y1_2_reg, x1_3_reg, y1_3_reg;
    logic signed [COORD_BITS-1:0] x1_4_reg, y1_4_reg, x1_5_reg, y1_5_reg;
    logic signed [DIFF_W-1:0]     bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [DIFF_W-1:0]     bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [DIFF_W-1:0]     bx3_reg, by3_reg, cx3_reg, cy3_reg;
    logic signed [PROD_W-1:0]     p_bxcy_reg, p_bycx_reg, p_bxbx_reg, p_byby_reg;
    logic signed [PROD_W-1:0]     p_cxcx_reg, p_cycy_reg;
    logic signed [SUM_W-1:0]      cross_reg, bb_reg, cc_reg;
    logic signed [D_W-1:0]        d_next, d4_reg, d5_reg;
    logic signed [BIG_W-1:0]      m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [XD_W-1:0]       xd_reg, yd_reg;
    logic signed [NUM_W-1:0]      num_x_reg, num_y_reg;
    logic [NUM_W-1:0]             nmag_x, nmag_y;
    logic [D_W-1:0]               dmag;
    div_word_t                    word_reg, word_next;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            pt[i] = $signed(coords[i*COORD_BITS +: COORD_BITS]);
        end
    end

    assign d_next = D_W'(cross_reg) <<< 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edge vectors from the first point
            x1_1_reg <= pt[0];
            y1_1_reg <= pt[1];
            bx1_reg  <= DIFF_W'(pt[2]) - DIFF_W'(pt[0]);
            by1_reg  <= DIFF_W'(pt[3]) - DIFF_W'(pt[1]);
            cx1_reg  <= DIFF_W'(pt[4]) - DIFF_W'(pt[0]);
            cy1_reg  <= DIFF_W'(pt[5]) - DIFF_W'(pt[1]);
            // products
            x1_2_reg   <= x1_1_reg;
            y1_2_reg   <= y1_1_reg;
            bx2_reg    <= bx1_reg;
            by2_reg    <= by1_reg;
            cx2_reg    <= cx1_reg;
            cy2_reg    <= cy1_reg;
            p_bxcy_reg <= PROD_W'(bx1_reg) * PROD_W'(cy1_reg);
            p_bycx_reg <= PROD_W'(by1_reg) * PROD_W'(cx1_reg);
            p_bxbx_reg <= PROD_W'(bx1_reg) * PROD_W'(bx1_reg);
            p_byby_reg <= PROD_W'(by1_reg) * PROD_W'(by1_reg);
            p_cxcx_reg <= PROD_W'(cx1_reg) * PROD_W'(cx1_reg);
            p_cycy_reg <= PROD_W'(cy1_reg) * PROD_W'(cy1_reg);
            // cross product and squared lengths
            x1_3_reg  <= x1_2_reg;
            y1_3_reg  <= y1_2_reg;
            bx3_reg   <= bx2_reg;
            by3_reg   <= by2_reg;
            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;
            cross_reg <= SUM_W'(p_bxcy_reg) - SUM_W'(p_bycx_reg);
            bb_reg    <= SUM_W'(p_bxbx_reg) + SUM_W'(p_byby_reg);
            cc_reg    <= SUM_W'(p_cxcx_reg) + SUM_W'(p_cycy_reg);
            // numerator terms
            x1_4_reg <= x1_3_reg;
            y1_4_reg <= y1_3_reg;
            d4_reg   <= d_next;
            m1_reg   <= BIG_W'(cy3_reg) * BIG_W'(bb_reg);
            m2_reg   <= BIG_W'(by3_reg) * BIG_W'(cc_reg);
            m3_reg   <= BIG_W'(bx3_reg) * BIG_W'(cc_reg);
            m4_reg   <= BIG_W'(cx3_reg) * BIG_W'(bb_reg);
            xd_reg   <= XD_W'(x1_3_reg) * XD_W'(d_next);
            yd_reg   <= XD_W'(y1_3_reg) * XD_W'(d_next);
            // full numerators of first*D + N
            x1_5_reg  <= x1_4_reg;
            y1_5_reg  <= y1_4_reg;
            d5_reg    <= d4_reg;
            num_x_reg <= NUM_W'(xd_reg) + NUM_W'(m1_reg) - NUM_W'(m2_reg);
            num_y_reg <= NUM_W'(yd_reg) + NUM_W'(m3_reg) - NUM_W'(m4_reg);
        end
    end

    always_comb
    begin
        nmag_x = num_x_reg[NUM_W-1] ? (~num_x_reg + 1'b1) : num_x_reg;
        nmag_y = num_y_reg[NUM_W-1] ? (~num_y_reg + 1'b1) : num_y_reg;
        dmag   = d5_reg[D_W-1] ? (~d5_reg + 1'b1) : d5_reg;
        word_next.vld        = v5_reg;
        word_next.deg        = (d5_reg == '0);
        word_next.sgn_x      = num_x_reg[NUM_W-1] ^ d5_reg[D_W-1];
        word_next.sgn_y      = num_y_reg[NUM_W-1] ^ d5_reg[D_W-1];
        word_next.x1         = x1_5_reg;
        word_next.y1         = y1_5_reg;
        word_next.dmag       = dmag;
        word_next.lane_x.rem = D_W'(nmag_x >> QW);
        word_next.lane_x.acc = nmag_x[QW-1:0];
        word_next.lane_y.rem = D_W'(nmag_y >> QW);
        word_next.lane_y.acc = nmag_y[QW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

>>> hdl/ccp_div_cell.sv
module ccp_div_cell
    import ccp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  div_word_t din,
    output div_word_t dout
);

    div_word_t word_reg, word_next;

    // one quotient bit per cell for both axes
    always_comb
    begin
        word_next        = din;
        word_next.lane_x = div_step(din.lane_x, din.dmag);
        word_next.lane_y = div_step(din.lane_y, din.dmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

>>> hdl/ccp_square.sv
module ccp_square
    import ccp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  div_word_t  din,
    output root_word_t dout
);

    logic [CTR_W-1:0]             qx_ext, qy_ext;
    logic [DX_W-1:0]              dx_neg, dy_neg;
    logic [5:0]                   v_reg;
    logic [5:0]                   deg_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg;
    logic signed [CTR_W-1:0]      ox_reg [6];
    logic signed [CTR_W-1:0]      oy_reg [6];
    logic signed [DX_W-1:0]       dx_reg, dy_reg;
    logic [MAG_W-1:0]             mx_reg, my_reg;
    logic [HH_W-1:0]              hh_x_reg, hh_y_reg;
    logic [HL_W-1:0]              hl_x_reg, hl_y_reg;
    logic [LL_W-1:0]              ll_x_reg, ll_y_reg;
    logic [RAD_W-1:0]             sq_x_reg, sq_y_reg;
    logic [RAD_W-1:0]             sum_reg;

    assign qx_ext = {1'b0, din.lane_x.acc};
    assign qy_ext = {1'b0, din.lane_y.acc};
    assign dx_neg = ~dx_reg + 1'b1;
    assign dy_neg = ~dy_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], din.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg <= {deg_reg[4:0], din.deg};
            // signed centre
            x1_reg    <= din.x1;
            y1_reg    <= din.y1;
            ox_reg[0] <= din.sgn_x ? $signed(~qx_ext + 1'b1) : $signed(qx_ext);
            oy_reg[0] <= din.sgn_y ? $signed(~qy_ext + 1'b1) : $signed(qy_ext);
            for (int i = 1; i < 6; i++)
            begin
                ox_reg[i] <= ox_reg[i-1];
                oy_reg[i] <= oy_reg[i-1];
            end
            // offset to the first point
            dx_reg <= DX_W'(x1_reg) - DX_W'(ox_reg[0]);
            dy_reg <= DX_W'(y1_reg) - DX_W'(oy_reg[0]);
            mx_reg <= dx_reg[DX_W-1] ? dx_neg[MAG_W-1:0] : dx_reg[MAG_W-1:0];
            my_reg <= dy_reg[DX_W-1] ? dy_neg[MAG_W-1:0] : dy_reg[MAG_W-1:0];
            // split squares into half-word partial products
            hh_x_reg <= HH_W'(mx_reg[MAG_W-1:HALF]) * HH_W'(mx_reg[MAG_W-1:HALF]);
            hl_x_reg <= HL_W'(mx_reg[MAG_W-1:HALF]) * HL_W'(mx_reg[HALF-1:0]);
            ll_x_reg <= LL_W'(mx_reg[HALF-1:0]) * LL_W'(mx_reg[HALF-1:0]);
            hh_y_reg <= HH_W'(my_reg[MAG_W-1:HALF]) * HH_W'(my_reg[MAG_W-1:HALF]);
            hl_y_reg <= HL_W'(my_reg[MAG_W-1:HALF]) * HL_W'(my_reg[HALF-1:0]);
            ll_y_reg <= LL_W'(my_reg[HALF-1:0]) * LL_W'(my_reg[HALF-1:0]);
            sq_x_reg <= (RAD_W'(hh_x_reg) << (2*HALF)) + (RAD_W'(hl_x_reg) << (HALF+1))
                        + RAD_W'(ll_x_reg);
            sq_y_reg <= (RAD_W'(hh_y_reg) << (2*HALF)) + (RAD_W'(hl_y_reg) << (HALF+1))
                        + RAD_W'(ll_y_reg);
            sum_reg  <= sq_x_reg + sq_y_reg;
        end
    end

    always_comb
    begin
        dout.vld  = v_reg[5];
        dout.deg  = deg_reg[5];
        dout.ox   = ox_reg[5];
        dout.oy   = oy_reg[5];
        dout.rem  = '0;
        dout.root = '0;
        dout.rad  = sum_reg;
    end

endmodule

>>> hdl/ccp_root_cell.sv
module ccp_root_cell
    import ccp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  root_word_t din,
    output root_word_t dout
);

    root_word_t       word_reg, word_next;
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    logic             ge;

    // one root bit per cell: bring down two radicand bits, try root*4+1
    always_comb
    begin
        t         = {din.rem[REM_W-3:0], din.rad[RAD_W-1 -: 2]};
        trial     = REM_W'({din.root, 2'b01});
        ge        = (t >= trial);
        word_next      = din;
        word_next.rem  = ge ? (t - trial) : t;
        word_next.root = {din.root[RADIUS_BITS-2:0], ge};
        word_next.rad  = din.rad << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign dout = word_reg;

endmodule

>>> hdl/ccp_checker.sv
module ccp_checker
    import ccp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [IN_PAD_W-1:0]  s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_PAD_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // a degenerate word carries all-zero data
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate word with nonzero data");

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // intake stops only while a result waits
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("intake stopped with no result pending");

    a_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("intake stopped without an output stall");

    // leaving reset the block is empty and ready
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid && s_tready)
        else $error("block not empty after reset");

endmodule

bind circumcircle_from_three_points ccp_checker u_ccp_checker (.*);
